@@ design/glyph_tile_shader_assert.svh @@
// Assertion macros for the glyph tile shader.
`ifndef GLYPH_TILE_SHADER_ASSERT_SVH
`define GLYPH_TILE_SHADER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph_tile_shader: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph_tile_shader: next-cycle check failed");

`endif

@@ design/gts_pkg.sv @@
`timescale 1ns / 1ps

package gts_pkg;

    localparam int GLYPHS_DEF    = 128;
    localparam int MAX_TILES_DEF = 256;

    // bits of one tile code
    localparam int CODE_BITS = 3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int COLOR_W     = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GLYPH_WIDTH  = 3'd0,
        REG_GLYPH_HEIGHT = 3'd1,
        REG_TILE_SIZE    = 3'd2,
        REG_FG_COLOR     = 3'd3,
        REG_BG_COLOR     = 3'd4
    } reg_index_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_SHADE = 1'b1
    } kind_t;

    typedef enum logic [CODE_BITS-1:0] {
        CODE_EMPTY    = 3'd0,
        CODE_FULL     = 3'd1,
        CODE_LOWER_R  = 3'd2,
        CODE_LOWER_L  = 3'd3,
        CODE_UPPER_R  = 3'd4,
        CODE_UPPER_L  = 3'd5,
        CODE_DIAMOND  = 3'd6,
        CODE_INV_DIAM = 3'd7
    } code_t;

endpackage

@@ design/gts_ram.sv @@
`timescale 1ns / 1ps

module gts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/glyph_tile_shader.sv @@
// glyph_tile_shader: glyph byte store with a one-pixel shape shader.
// Input channel: present an item on the field ports with start high; it is
// taken at the rising edge where start is high and busy is low. busy stays
// low, so one item can be taken every cycle, load or shade in any mix.
// A load beat (kind = 0) writes one glyph byte and yields no result.
// A shade beat (kind = 1) yields one result: done is high for exactly one
// cycle, from the s1 and result registers, with pixel_color, lit and
// in_range. Results leave in request order; the receiver cannot stall and
// must take each beat in the cycle it is shown.
// Throughput is one item per clock, set by the single read of each of the two
// byte banks. Glyph bytes sit in an even and an odd bank, so the two bytes a
// tile code may straddle are fetched in the same cycle. A shade issued the
// cycle after a load of the same byte sees the new byte.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the edge;
// write only while no shade result is pending. Unknown indexes are dropped.
// Reset (rst_n low, asynchronous) clears the pipeline and restores register
// defaults; glyph bytes are undefined until loaded, and no clearing pass runs.
`timescale 1ns / 1ps
`include "glyph_tile_shader_assert.svh"

module glyph_tile_shader #(
    parameter int GLYPHS    = gts_pkg::GLYPHS_DEF,
    parameter int MAX_TILES = gts_pkg::MAX_TILES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [6:0]                      glyph_index,
    input  logic [6:0]                      byte_offset,
    input  logic [7:0]                      data_byte,
    input  logic [3:0]                      tile_col,
    input  logic [3:0]                      tile_row,
    input  logic [7:0]                      sub_x,
    input  logic [7:0]                      sub_y,
    // result channel
    output logic                            done,
    output logic [gts_pkg::COLOR_W-1:0]     pixel_color,
    output logic                            lit,
    output logic                            in_range,
    // configuration port
    input  logic                            cfg_we,
    input  logic [gts_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // bytes per glyph and the whole store
    localparam int STRIDE     = (MAX_TILES * gts_pkg::CODE_BITS + 7) / 8;
    localparam int DEPTH      = GLYPHS * STRIDE;
    localparam int BANK_DEPTH = (DEPTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    // wide enough for any 7-bit glyph index, any byte position, plus one
    localparam int AW         = $clog2(DEPTH + 128 * STRIDE + 1024);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [4:0]                  glyph_width_reg;
    logic [4:0]                  glyph_height_reg;
    logic [7:0]                  tile_size_reg;
    logic [gts_pkg::COLOR_W-1:0] fg_color_reg;
    logic [gts_pkg::COLOR_W-1:0] bg_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_width_reg  <= 5'd8;
            glyph_height_reg <= 5'd16;
            tile_size_reg    <= 8'd2;
            fg_color_reg     <= '1;
            bg_color_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (gts_pkg::reg_index_t'(cfg_index))
                gts_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_wdata[4:0];
                gts_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[4:0];
                gts_pkg::REG_TILE_SIZE:    tile_size_reg    <= cfg_wdata[7:0];
                gts_pkg::REG_FG_COLOR:     fg_color_reg     <= cfg_wdata[gts_pkg::COLOR_W-1:0];
                gts_pkg::REG_BG_COLOR:     bg_color_reg     <= cfg_wdata[gts_pkg::COLOR_W-1:0];
                default:                   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // issue: decode the beat, form byte addresses, launch RAM access
    // ---------------------------------------------------------------
    logic accept;
    logic is_shade;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_shade = (gts_pkg::kind_t'(kind) == gts_pkg::KIND_SHADE);

    logic [AW-1:0] glyph_base;
    assign glyph_base = AW'(glyph_index) * AW'(STRIDE);

    // load path
    logic          load_ok;
    logic [AW-1:0] load_addr;
    logic          wr_even;
    logic          wr_odd;

    assign load_ok   = (11'(glyph_index) < 11'(GLYPHS)) && (8'(byte_offset) < 8'(STRIDE));
    assign load_addr = glyph_base + AW'(byte_offset);
    assign wr_even   = accept && !is_shade && load_ok && !load_addr[0];
    assign wr_odd    = accept && !is_shade && load_ok && load_addr[0];

    // shade path: tile index, first code bit, byte holding it
    logic [9:0]    tile;
    logic [11:0]   bit_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_addr_inc;
    logic [AW-1:0] even_addr;
    logic [AW-1:0] odd_addr;
    logic          rd_en;
    logic          shade_ok;

    assign tile        = 10'(tile_row) * 10'(glyph_width_reg) + 10'(tile_col);
    assign bit_pos     = 12'(tile) * 12'(gts_pkg::CODE_BITS);
    assign rd_addr     = glyph_base + AW'(bit_pos[11:3]);
    assign rd_addr_inc = rd_addr + AW'(1);
    // the code's first byte and the next one lie in opposite banks
    assign even_addr   = rd_addr[0] ? rd_addr_inc : rd_addr;
    assign odd_addr    = rd_addr[0] ? rd_addr : rd_addr_inc;
    assign rd_en       = accept && is_shade;

    assign shade_ok = (11'(glyph_index) < 11'(GLYPHS))
                   && (5'(tile_col) < glyph_width_reg)
                   && (5'(tile_row) < glyph_height_reg)
                   && (tile < 10'(MAX_TILES))
                   && (sub_x < tile_size_reg)
                   && (sub_y < tile_size_reg);

    // ---------------------------------------------------------------
    // byte banks: even and odd global byte addresses
    // ---------------------------------------------------------------
    logic [7:0] even_byte;
    logic [7:0] odd_byte;

    gts_ram #(
        .WIDTH  (8),
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BANK_AW)
    ) u_even_bank (
        .clk   (clk),
        .we    (wr_even),
        .waddr (load_addr[BANK_AW:1]),
        .wdata (data_byte),
        .re    (rd_en),
        .raddr (even_addr[BANK_AW:1]),
        .rdata (even_byte)
    );

    gts_ram #(
        .WIDTH  (8),
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BANK_AW)
    ) u_odd_bank (
        .clk   (clk),
        .we    (wr_odd),
        .waddr (load_addr[BANK_AW:1]),
        .wdata (data_byte),
        .re    (rd_en),
        .raddr (odd_addr[BANK_AW:1]),
        .rdata (odd_byte)
    );

    // ---------------------------------------------------------------
    // hold the shade beat alongside the RAM read
    // ---------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_ok_reg;
    logic       s1_first_odd_reg;
    logic [2:0] s1_bit_off_reg;
    logic [7:0] s1_x_reg;
    logic [7:0] s1_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_ok_reg        <= shade_ok;
            s1_first_odd_reg <= rd_addr[0];
            s1_bit_off_reg   <= bit_pos[2:0];
            s1_x_reg         <= sub_x;
            s1_y_reg         <= sub_y;
        end
    end

    // ---------------------------------------------------------------
    // unpack the code and apply the shape rule
    // ---------------------------------------------------------------
    logic [15:0]    byte_pair;
    logic [15:0]    pair_shifted;
    gts_pkg::code_t code;

    // MSB-first bit order across first byte then next byte
    assign byte_pair    = s1_first_odd_reg ? {odd_byte, even_byte} : {even_byte, odd_byte};
    assign pair_shifted = byte_pair << s1_bit_off_reg;
    // assemble LSB-first
    assign code = gts_pkg::code_t'({pair_shifted[13], pair_shifted[14], pair_shifted[15]});

    logic [9:0] s_w;
    logic [9:0] h_w;
    logic [9:0] x_w;
    logic [9:0] y_w;
    logic       diamond;
    logic       shape_lit;

    assign s_w = 10'(tile_size_reg);
    assign h_w = 10'(tile_size_reg[7:1]);
    assign x_w = 10'(s1_x_reg);
    assign y_w = 10'(s1_y_reg);

    always_comb
    begin
        priority if (x_w >= h_w && y_w < h_w)
        begin
            diamond = (y_w + h_w) >= (x_w + 10'd1);
        end
        else if (x_w >= h_w)
        begin
            diamond = (y_w + x_w + 10'd1) < (s_w + h_w);
        end
        else if (y_w < h_w)
        begin
            diamond = (y_w + x_w + h_w) >= s_w;
        end
        else
        begin
            diamond = y_w < (x_w + h_w);
        end
    end

    always_comb
    begin
        unique case (code)
            gts_pkg::CODE_EMPTY:    shape_lit = 1'b0;
            gts_pkg::CODE_FULL:     shape_lit = 1'b1;
            gts_pkg::CODE_LOWER_R:  shape_lit = (y_w + x_w + 10'd1) >= s_w;
            gts_pkg::CODE_LOWER_L:  shape_lit = y_w >= x_w;
            gts_pkg::CODE_UPPER_R:  shape_lit = y_w <= x_w;
            gts_pkg::CODE_UPPER_L:  shape_lit = (y_w + x_w + 10'd1) <= s_w;
            gts_pkg::CODE_DIAMOND:  shape_lit = diamond;
            gts_pkg::CODE_INV_DIAM: shape_lit = !diamond;
            default:                shape_lit = 1'b0;
        endcase
    end

    logic lit_next;
    assign lit_next = s1_ok_reg && shape_lit;

    // ---------------------------------------------------------------
    // result register: one-cycle strobe
    // ---------------------------------------------------------------
    logic                        done_reg;
    logic [gts_pkg::COLOR_W-1:0] pixel_color_reg;
    logic                        lit_reg;
    logic                        in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            pixel_color_reg <= lit_next ? fg_color_reg : bg_color_reg;
            lit_reg         <= lit_next;
            in_range_reg    <= s1_ok_reg;
        end
    end

    assign done        = done_reg;
    assign pixel_color = pixel_color_reg;
    assign lit         = lit_reg;
    assign in_range    = in_range_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `GTS_ASSERT_NEXT(a_read_gives_result, s1_valid_reg, done)
    `GTS_ASSERT_NOW(a_result_has_read, done, $past(s1_valid_reg))
    `GTS_ASSERT_NOW(a_no_write_on_read, wr_even || wr_odd, !rd_en)
    `GTS_ASSERT_NOW(a_range_unlit, done && !in_range, !lit)
    `GTS_ASSERT_NOW(a_color_match, done,
                    pixel_color == (lit ? fg_color_reg : bg_color_reg))

endmodule
